[rtl/core/cywt_pkg.sv]
// ----------------------------------------------------------------------------
// cywt_pkg
// Shared types and constants of the circular yaw window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cywt_pkg;

    // fixed field widths
    localparam int CHANNEL_W  = 3;
    localparam int YAW_W      = 9;
    localparam int CFG_W      = 10;
    localparam int OFFSET_W   = 10;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // magnitude of yaw + shift fits in 9 bits (at most 434)
    localparam int MAG_W      = 9;
    // remainder steps below this bit run in the second stage
    localparam int SPLIT_STEP = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCLE_SIZE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 1'd1;

    // register reset values
    localparam logic [CFG_W-1:0] CIRCLE_RESET = 10'd360;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd140;

    // angle shift and per-channel state reset values
    localparam int YAW_SHIFT  = 179;
    localparam int RESET_LOW  = 100;
    localparam int RESET_HIGH = 200;

    // control fields that travel with an item through the pipeline
    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic                 hold_key;
        logic                 in_range;
    } item_ctl_t;

endpackage

`default_nettype wire

[rtl/core/cywt_wrap.sv]
// ----------------------------------------------------------------------------
// cywt_wrap
// Two-stage pipeline that maps a yaw angle onto the circle:
// (yaw + 179) reduced modulo the circle size by restoring subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module cywt_wrap (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           adv,
    input  wire logic                           in_fire,
    input  wire cywt_pkg::item_ctl_t            ctl_in,
    input  wire logic [cywt_pkg::YAW_W-1:0]     yaw_angle,
    input  wire logic [cywt_pkg::CFG_W-1:0]     circle,
    output logic                                p1_valid,
    output cywt_pkg::item_ctl_t                 p1_ctl,
    output logic [cywt_pkg::CFG_W-1:0]          p1_cur
);
    import cywt_pkg::*;

    localparam int SH_W = CFG_W + MAG_W;

    logic                    p0_valid_reg;
    item_ctl_t               p0_ctl_reg;
    logic                    p0_neg_reg;
    logic [MAG_W-1:0]        p0_mag_reg;
    logic                    p1_valid_reg;
    item_ctl_t               p1_ctl_reg;
    logic                    p1_neg_reg;
    logic [MAG_W-1:0]        p1_rem_reg;
    logic signed [YAW_W:0]   shifted;
    logic [MAG_W-1:0]        mag;
    logic [MAG_W-1:0]        rem_hi;
    logic [MAG_W-1:0]        rem_lo;

    // one compare-subtract step of the remainder
    function automatic logic [MAG_W-1:0] rem_step(
        input logic [MAG_W-1:0] rem,
        input logic [CFG_W-1:0] c,
        input int               k
    );
        logic [SH_W-1:0] sh;
        logic [MAG_W-1:0] r;
        sh = SH_W'(c) << k;
        r  = rem;
        if (sh <= SH_W'(rem))
        begin
            r = rem - MAG_W'(sh);
        end
        return r;
    endfunction

    // shift the yaw and split into sign and magnitude
    assign shifted = $signed({yaw_angle[YAW_W-1], yaw_angle}) + (YAW_W+1)'(YAW_SHIFT);
    assign mag     = shifted[YAW_W] ? MAG_W'(-shifted) : MAG_W'(shifted);

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p0_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_fire)
        begin
            p0_ctl_reg <= ctl_in;
            p0_neg_reg <= shifted[YAW_W];
            p0_mag_reg <= mag;
        end
    end

    // upper remainder steps
    always_comb
    begin
        rem_hi = p0_mag_reg;
        for (int k = MAG_W - 1; k >= SPLIT_STEP; k--)
        begin
            rem_hi = rem_step(rem_hi, circle, k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ctl_reg <= p0_ctl_reg;
            p1_neg_reg <= p0_neg_reg;
            p1_rem_reg <= rem_hi;
        end
    end

    // lower remainder steps and sign fix
    always_comb
    begin
        rem_lo = p1_rem_reg;
        for (int k = SPLIT_STEP - 1; k >= 0; k--)
        begin
            rem_lo = rem_step(rem_lo, circle, k);
        end
        if (p1_neg_reg && (rem_lo != '0))
        begin
            p1_cur = circle - CFG_W'(rem_lo);
        end
        else
        begin
            p1_cur = CFG_W'(rem_lo);
        end
    end

    assign p1_valid = p1_valid_reg;
    assign p1_ctl   = p1_ctl_reg;

endmodule

`default_nettype wire

[rtl/core/cywt_mem.sv]
// ----------------------------------------------------------------------------
// cywt_mem
// Per-channel state memory, registered read, one write port.
// Entries never written read as their reset values through valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cywt_mem #(
    parameter  int NUM_CHANNELS = 6,
    parameter  int ANGLE_BITS   = 10,
    localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
    localparam int ENTRY_W      = 4 * ANGLE_BITS + 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [ENTRY_W-1:0] wr_data,
    output logic      [ENTRY_W-1:0] rd_data
);
    import cywt_pkg::*;

    logic [ENTRY_W-1:0]      mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic [ADDR_W-1:0]       rd_addr_reg;
    logic                    rd_vld_reg;

    // reset contents: {reseed, armed, midpoint, high, low, previous}
    function automatic logic [ENTRY_W-1:0] reset_entry(input logic [ADDR_W-1:0] a);
        logic [ANGLE_BITS-1:0] prev;
        logic [ANGLE_BITS-1:0] lo;
        logic [ANGLE_BITS-1:0] hi;
        prev = (32'(a) == 2) ? ANGLE_BITS'(RESET_HIGH) : ANGLE_BITS'(RESET_LOW);
        lo   = (32'(a) == 0) ? ANGLE_BITS'(RESET_LOW)  : '0;
        hi   = (32'(a) == 0) ? ANGLE_BITS'(RESET_HIGH) : '0;
        return {1'b1, 1'b0, {ANGLE_BITS{1'b0}}, hi, lo, prev};
    endfunction

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : reset_entry(rd_addr_reg);

endmodule

`default_nettype wire

[rtl/core/cywt_update.sv]
// ----------------------------------------------------------------------------
// cywt_update
// Window update for one item: tracking drags the window, clamp mode latches
// the opposite midpoint and limits the offset. Produces new state and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cywt_update #(
    parameter  int ANGLE_BITS = 10,
    localparam int ENTRY_W    = 4 * ANGLE_BITS + 2
) (
    input  wire cywt_pkg::item_ctl_t             ctl,
    input  wire logic [cywt_pkg::CFG_W-1:0]      cur,
    input  wire logic [cywt_pkg::CFG_W-1:0]      circle,
    input  wire logic [cywt_pkg::CFG_W-1:0]      width,
    input  wire logic [ENTRY_W-1:0]              entry_in,
    output logic      [ENTRY_W-1:0]              entry_out,
    output logic      [cywt_pkg::OFFSET_W-1:0]   offset
);
    import cywt_pkg::*;

    localparam int AB = ANGLE_BITS;
    localparam int CW = ((AB > 11) ? AB : 11) + 3;

    typedef logic signed [CW-1:0] val_t;

    logic [AB-1:0] prev_st;
    logic [AB-1:0] lo_st;
    logic [AB-1:0] hi_st;
    logic [AB-1:0] mid_st;
    logic          armed_st;
    logic          reseed_st;
    logic [AB-1:0] lo_new;
    logic [AB-1:0] hi_new;
    logic [AB-1:0] mid_new;
    logic          armed_new;
    logic          reseed_new;
    val_t          c;
    val_t          w;
    val_t          cu;
    val_t          lo_v;
    val_t          hi_v;
    val_t          mid_v;
    val_t          fwd_dist;
    val_t          res;

    // shortest signed difference from a to b on a circle of size m
    function automatic val_t wrap_diff(input val_t a, input val_t b, input val_t m);
        val_t half;
        val_t d;
        val_t r;
        half = m >>> 1;
        d    = b - a;
        r    = d;
        if (b >= a)
        begin
            if (d > half)
            begin
                r = d - m;
            end
        end
        else if ((a - b) > half)
        begin
            r = d + m;
        end
        return r;
    endfunction

    assign {reseed_st, armed_st, mid_st, hi_st, lo_st, prev_st} = entry_in;

    always_comb
    begin
        c          = val_t'(circle);
        w          = val_t'(width);
        cu         = val_t'(cur);
        lo_v       = val_t'(lo_st);
        hi_v       = val_t'(hi_st);
        mid_v      = val_t'(mid_st);
        fwd_dist   = '0;
        res        = '0;
        mid_new    = mid_st;
        armed_new  = armed_st;
        reseed_new = reseed_st;
        lo_new     = lo_st;
        hi_new     = hi_st;

        if (ctl.hold_key)
        begin
            // clamp mode: latch the opposite midpoint once
            reseed_new = 1'b1;
            if (armed_st)
            begin
                armed_new = 1'b0;
                mid_v = (lo_v + hi_v + c + ((hi_v > lo_v) ? val_t'(0) : c)) >>> 1;
                if (mid_v > c)
                begin
                    mid_v = mid_v - c;
                end
                mid_new = mid_v[AB-1:0];
                mid_v   = val_t'(mid_new);
            end
            fwd_dist = cu - mid_v + ((cu > mid_v) ? val_t'(0) : c);
            if (fwd_dist < ((c - w) >>> 1))
            begin
                res = '0;
            end
            else if (fwd_dist > ((c + w) >>> 1))
            begin
                res = w;
            end
            else
            begin
                res = c + cu - lo_v;
                if (res >= c)
                begin
                    res = res - c;
                end
            end
        end
        else
        begin
            // tracking mode: drag the window along
            armed_new = 1'b1;
            if (wrap_diff(val_t'(prev_st), cu, c) > 0)
            begin
                if (wrap_diff(cu, hi_v, c) < 0)
                begin
                    hi_v = cu;
                    lo_v = (hi_v > w) ? (hi_v - w) : (c + hi_v - w);
                end
            end
            else if ((val_t'(prev_st) != cu) && (wrap_diff(cu, lo_v, c) > 0))
            begin
                lo_v = cu;
                hi_v = lo_v + w;
                if (hi_v >= c)
                begin
                    hi_v = hi_v - c;
                end
            end
            // first tracking item after reset or a hold re-seeds low channels
            if (reseed_st)
            begin
                reseed_new = 1'b0;
                if (ctl.channel inside {3'd0, 3'd1})
                begin
                    lo_v = cu - w;
                    if (lo_v < 0)
                    begin
                        lo_v = lo_v + c;
                    end
                    hi_v = lo_v + w;
                    if (hi_v > c)
                    begin
                        hi_v = hi_v - c;
                    end
                end
                else if (ctl.channel inside {3'd2, 3'd3})
                begin
                    lo_v = cu;
                    hi_v = lo_v + w;
                    if (hi_v > c)
                    begin
                        hi_v = hi_v - c;
                    end
                end
            end
            lo_new = lo_v[AB-1:0];
            hi_new = hi_v[AB-1:0];
            res    = c + cu - val_t'(lo_new);
            if (res >= c)
            begin
                res = res - c;
            end
        end
    end

    assign entry_out = {reseed_new, armed_new, mid_new, hi_new, lo_new, AB'(cur)};
    assign offset    = res[OFFSET_W-1:0];

endmodule

`default_nettype wire

[rtl/core/circular_yaw_window_tracker.sv]
// ----------------------------------------------------------------------------
// circular_yaw_window_tracker
// Per-channel yaw window tracker on a circular angle scale. Channel state
// lives in a small synchronous memory, read in the stage ahead of the update.
// ----------------------------------------------------------------------------
//  port group   dir  contents
//  s_axis_*     in   tdata: [2:0] channel, [11:3] yaw_angle; tuser: hold_key
//  m_axis_*     out  tdata: [9:0] window_offset
//  cfg_*        in   index 0 circle_size, index 1 window_width
//
//  one item per cycle while the output is not stalled; each item passes two remainder
//  stages, then the state read-modify-write stage, then the output register
//  state of the item just written is forwarded to a following item of the
//  same channel, so back-to-back items on one channel run at full rate
//  reset restores every channel's state at once (valid bits, no clear pass)
//  a stalled output freezes the whole pipeline; tready follows that stall
// ----------------------------------------------------------------------------
`default_nettype none

module circular_yaw_window_tracker #(
    parameter int NUM_CHANNELS = 6,
    parameter int ANGLE_BITS   = 10
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input items
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [cywt_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // channel, yaw_angle
    input  wire logic                                s_axis_tuser,  // hold_key
    // result items
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [cywt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // window_offset
    // configuration writes
    input  wire logic                                cfg_we,
    input  wire logic [cywt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cywt_pkg::CFG_W-1:0]          cfg_data
);
    import cywt_pkg::*;

    localparam int ADDR_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ENTRY_W = 4 * ANGLE_BITS + 2;

    logic [CFG_W-1:0]    circle_size_reg;
    logic [CFG_W-1:0]    window_width_reg;
    logic [CFG_W-1:0]    circle_eff;
    logic [CFG_W-1:0]    width_eff;
    logic                adv;
    logic                in_fire;
    item_ctl_t           ctl_in;
    logic                p1_valid;
    item_ctl_t           p1_ctl;
    logic [CFG_W-1:0]    p1_cur;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                p2_valid_reg;
    item_ctl_t           p2_ctl_reg;
    logic [CFG_W-1:0]    p2_cur_reg;
    logic                byp_reg;
    logic [ENTRY_W-1:0]  byp_data_reg;
    logic [ENTRY_W-1:0]  entry_cur;
    logic [ENTRY_W-1:0]  entry_new;
    logic [OFFSET_W-1:0] offset;
    logic                wr_en;
    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circle_size_reg  <= CIRCLE_RESET;
            window_width_reg <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CIRCLE_SIZE:  circle_size_reg  <= cfg_data;
                CFG_WINDOW_WIDTH: window_width_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // effective circle and width after range limits
    always_comb
    begin
        circle_eff = (circle_size_reg < CFG_W'(2)) ? CFG_W'(2) : circle_size_reg;
        width_eff  = (window_width_reg == '0) ? CFG_W'(1) : window_width_reg;
        if (width_eff >= circle_eff)
        begin
            width_eff = circle_eff - CFG_W'(1);
        end
    end

    // handshake: the pipeline moves whenever the output slot can take a result
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign in_fire       = s_axis_tvalid && adv;

    assign ctl_in.channel  = s_axis_tdata[CHANNEL_W-1:0];
    assign ctl_in.hold_key = s_axis_tuser;
    assign ctl_in.in_range = (32'(s_axis_tdata[CHANNEL_W-1:0]) < NUM_CHANNELS);

    // angle onto the circle
    cywt_wrap u_wrap (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_fire   (in_fire),
        .ctl_in    (ctl_in),
        .yaw_angle (s_axis_tdata[CHANNEL_W +: YAW_W]),
        .circle    (circle_eff),
        .p1_valid  (p1_valid),
        .p1_ctl    (p1_ctl),
        .p1_cur    (p1_cur)
    );

    // state read in the stage ahead of the update
    assign rd_addr = p1_ctl.in_range ? ADDR_W'(p1_ctl.channel) : '0;
    assign wr_en   = adv && p2_valid_reg && p2_ctl_reg.in_range;

    cywt_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(p2_ctl_reg.channel)),
        .wr_data (entry_new),
        .rd_data (rd_data)
    );

    // update stage registers and same-channel forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg <= p1_valid;
            byp_reg      <= wr_en && p1_valid && p1_ctl.in_range &&
                            (p1_ctl.channel == p2_ctl_reg.channel);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_ctl_reg   <= p1_ctl;
            p2_cur_reg   <= p1_cur;
            byp_data_reg <= entry_new;
        end
    end

    assign entry_cur = byp_reg ? byp_data_reg : rd_data;

    cywt_update #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_update (
        .ctl       (p2_ctl_reg),
        .cur       (p2_cur_reg),
        .circle    (circle_eff),
        .width     (width_eff),
        .entry_in  (entry_cur),
        .entry_out (entry_new),
        .offset    (offset)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && p2_valid_reg)
        begin
            out_offset_reg <= p2_ctl_reg.in_range ? offset : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_offset_reg);

    // input is refused only behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input refused without an output stall");

    // forwarded state always belongs to an item in the update stage
    a_bypass_item: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> p2_valid_reg)
        else $error("forwarding flag set with an empty update stage");

    // a state write always produces a result in the next cycle
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> m_axis_tvalid)
        else $error("state written without a result");

    // an unknown channel gives a zero offset
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && p2_valid_reg && !p2_ctl_reg.in_range) |=> (m_axis_tdata == '0))
        else $error("out-of-range channel gave a nonzero offset");

endmodule

`default_nettype wire

[tb/circular_yaw_window_tracker_tb.sv]
// ----------------------------------------------------------------------------
// circular_yaw_window_tracker_tb
// Self-checking bench for the circular yaw window tracker. A short table of
// directed items comes first, then random phases under several circle and
// window settings. Every accepted item is run through a local model of the
// per-channel window state; results are checked in order against it or the
// typed row value; random idling on both streams, one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module circular_yaw_window_tracker_tb;

    import cywt_pkg::*;

    localparam int NUM_CH      = 6;
    localparam int ANGLE_MASK  = (1 << 10) - 1;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 195;
    localparam int NUM_ROWS    = 22;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 64;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [2:0] channel, [11:3] yaw_angle
    logic                  s_axis_tuser;   // hold_key
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [9:0] window_offset
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    circular_yaw_window_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // window state model
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] circle_reg;
    logic [CFG_W-1:0] width_reg;
    int               last_pos    [NUM_CH];
    int               win_lo      [NUM_CH];
    int               win_hi      [NUM_CH];
    int               mid_latched [NUM_CH];
    bit               armed       [NUM_CH];
    bit               reseed      [NUM_CH];

    task automatic reset_window_state();
        circle_reg = CIRCLE_RESET;
        width_reg  = WIDTH_RESET;
        for (int i = 0; i < NUM_CH; i++)
        begin
            last_pos[i]    = (i == 2) ? RESET_HIGH : RESET_LOW;
            win_lo[i]      = (i == 0) ? RESET_LOW : 0;
            win_hi[i]      = (i == 0) ? RESET_HIGH : 0;
            mid_latched[i] = 0;
            armed[i]       = 1'b0;
            reseed[i]      = 1'b1;
        end
    endtask

    // shortest signed step from a to b around a circle of size c
    function automatic int circ_delta(input int a, input int b, input int c);
        int half;
        int d;
        half = c / 2;
        d    = b - a;
        if (b >= a)
        begin
            if (d > half)
                return d - c;
        end
        else if (a - b > half)
        begin
            return d + c;
        end
        return d;
    endfunction

    function automatic logic [OFFSET_W-1:0] track_offset(input logic [CHANNEL_W-1:0] ch,
                                                         input logic hold,
                                                         input logic signed [YAW_W-1:0] yaw);
        int c;
        int w;
        int cur;
        int prev;
        int lo;
        int hi;
        int mid;
        int d;
        int res;
        if (ch >= NUM_CH)
            return '0;
        c = (circle_reg < 2) ? 2 : int'(circle_reg);
        w = (width_reg < 1) ? 1 : int'(width_reg);
        if (w >= c)
            w = c - 1;
        cur = (int'(yaw) + YAW_SHIFT) % c;
        if (cur < 0)
            cur += c;
        prev         = last_pos[ch];
        last_pos[ch] = cur & ANGLE_MASK;
        lo           = win_lo[ch];
        hi           = win_hi[ch];
        if (hold)
        begin
            // clamp mode: latch the point opposite the window middle once
            reseed[ch] = 1'b1;
            if (armed[ch])
            begin
                armed[ch] = 1'b0;
                mid = (lo + hi + c + ((hi > lo) ? 0 : c)) >> 1;
                if (mid > c)
                    mid -= c;
                mid_latched[ch] = mid & ANGLE_MASK;
            end
            mid = mid_latched[ch];
            d   = cur - mid + ((cur > mid) ? 0 : c);
            if (d < ((c - w) >> 1))
                res = 0;
            else if (d > ((c + w) >> 1))
                res = w;
            else
            begin
                res = c + cur - lo;
                if (res >= c)
                    res -= c;
            end
        end
        else
        begin
            // tracking mode: drag the window by motion past its edges
            armed[ch] = 1'b1;
            if (circ_delta(prev, cur, c) > 0)
            begin
                if (circ_delta(cur, hi, c) < 0)
                begin
                    hi = cur;
                    lo = (hi > w) ? hi - w : c + hi - w;
                end
            end
            else if (prev != cur && circ_delta(cur, lo, c) > 0)
            begin
                lo = cur;
                hi = lo + w;
                if (hi >= c)
                    hi -= c;
            end
            // first tracking item after reset or a hold re-seeds some channels
            if (reseed[ch])
            begin
                reseed[ch] = 1'b0;
                if (ch == 0 || ch == 1)
                begin
                    lo = cur - w;
                    if (lo < 0)
                        lo += c;
                    hi = lo + w;
                    if (hi > c)
                        hi -= c;
                end
                else if (ch == 2 || ch == 3)
                begin
                    lo = cur;
                    hi = lo + w;
                    if (hi > c)
                        hi -= c;
                end
            end
            win_lo[ch] = lo & ANGLE_MASK;
            win_hi[ch] = hi & ANGLE_MASK;
            res = c + cur - win_lo[ch];
            if (res >= c)
                res -= c;
        end
        return res[OFFSET_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // bookkeeping
    // ------------------------------------------------------------------------
    logic [OFFSET_W-1:0] offset_queue [$];
    int                  error_count;
    int                  item_count;
    int                  result_count;
    int                  clamp_count;
    int                  unused_ch_count;
    int                  cycle_count;
    bit                  quiet;
    bit                  long_hold_req;

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold-off, in-order checking
    // ------------------------------------------------------------------------
    initial
    begin : result_side
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (offset_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, m_axis_tdata);
                end
                else if (m_axis_tdata !== {{(OUT_DATA_W-OFFSET_W){1'b0}}, offset_queue[0]})
                begin
                    error_count++;
                    $display("%0t: window_offset mismatch, expected %0d, actual %0d",
                             $time, offset_queue[0], m_axis_tdata);
                    void'(offset_queue.pop_front());
                end
                else
                begin
                    void'(offset_queue.pop_front());
                end
            end
            // pick tready for the next edge
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && rst_n && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic offer_item(input logic [CHANNEL_W-1:0] ch, input logic hold,
                              input int yaw, input bit typed, input int want);
        logic [YAW_W-1:0]    yaw_bits;
        logic [OFFSET_W-1:0] pred;
        yaw_bits = yaw[YAW_W-1:0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-YAW_W-CHANNEL_W){1'b0}}, yaw_bits, ch};
        s_axis_tuser  <= hold;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = track_offset(ch, hold, yaw_bits);
        offset_queue.push_back(typed ? want[OFFSET_W-1:0] : pred);
        item_count++;
        if (ch >= NUM_CH)
            unused_ch_count++;
        else if (hold)
            clamp_count++;
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // sender pauses until every result is back, then lets the pipe settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (offset_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_CIRCLE_SIZE)
            circle_reg = val;
        else
            width_reg = val;
    endtask

    typedef struct {
        logic [CHANNEL_W-1:0] ch;
        logic                 hold;
        int                   yaw;
        bit                   typed;
        int                   want;
    } stim_row_t;

    stim_row_t directed_rows [NUM_ROWS];
    int        phase_circle  [NUM_PHASES];
    int        phase_width   [NUM_PHASES];
    int        walk_yaw      [8];
    bit        held          [8];

    initial
    begin : stimulus
        logic [CHANNEL_W-1:0] ch;
        int                   yaw;
        int                   pick;

        clk           = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_CIRCLE_SIZE;
        cfg_data      <= '0;
        error_count     = 0;
        item_count      = 0;
        result_count    = 0;
        clamp_count     = 0;
        unused_ch_count = 0;
        quiet           = 1'b0;
        long_hold_req   = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            walk_yaw[i] = 0;
            held[i]     = 1'b0;
        end
        reset_window_state();

        // channel, hold, yaw, typed, expected offset
        directed_rows = '{
            '{3'd0, 1'b0,    0, 1'b1, 140},   // first track on channel 0 re-seeds
            '{3'd2, 1'b0,    0, 1'b1,   0},   // channel 2 window starts at the angle
            '{3'd6, 1'b0,  100, 1'b1,   0},   // unused channel
            '{3'd7, 1'b1, -256, 1'b1,   0},   // unused channel, most negative yaw
            '{3'd4, 1'b0,    0, 1'b1, 140},   // no re-seed, drag from reset window
            '{3'd1, 1'b0,  180, 1'b1, 140},   // top of range
            '{3'd1, 1'b0, -180, 1'b1, 140},   // -180 and 180 are the same point
            '{3'd0, 1'b1,  255, 1'b1,  35},   // latch midpoint, yaw beyond range
            '{3'd0, 1'b1, -256, 1'b1, 140},   // clamp high
            '{3'd0, 1'b1,  120, 1'b1,   0},   // clamp low
            '{3'd0, 1'b1,    0, 1'b0,   0},
            '{3'd0, 1'b0,    0, 1'b0,   0},   // re-seed after hold
            '{3'd5, 1'b1,    0, 1'b0,   0},   // hold before any latch
            '{3'd5, 1'b0,  -90, 1'b0,   0},
            '{3'd5, 1'b0,  -60, 1'b0,   0},
            '{3'd5, 1'b0, -120, 1'b0,   0},
            '{3'd3, 1'b0, -179, 1'b1,   0},   // channel 3 re-seed at zero
            '{3'd3, 1'b0,  170, 1'b0,   0},
            '{3'd3, 1'b1,  170, 1'b0,   0},
            '{3'd2, 1'b0, -100, 1'b0,   0},
            '{3'd4, 1'b1, -180, 1'b0,   0},
            '{3'd1, 1'b1,   90, 1'b0,   0}
        };
        // circle / window settings; zero and all-ones among them
        phase_circle = '{360,   2, 1023, 1023,  5, 0, 100, 361, 720, 360};
        phase_width  = '{140,   1, 1022,    0, 10, 0,  99, 180,   3, 140};

        // reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            offer_item(directed_rows[r].ch, directed_rows[r].hold, directed_rows[r].yaw,
                       directed_rows[r].typed, directed_rows[r].want);
            sender_gap();
        end
        drain_results();

        // random phases, one register setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                write_reg(CFG_CIRCLE_SIZE, CFG_W'(phase_circle[p]));
                write_reg(CFG_WINDOW_WIDTH, CFG_W'(phase_width[p]));
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            quiet = (p == NUM_PHASES - 1);
            if (p == 2)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mostly live channels, a few unused ones
                ch = ($urandom_range(0, 99) < 92) ? CHANNEL_W'($urandom_range(0, NUM_CH - 1))
                                                  : CHANNEL_W'($urandom_range(NUM_CH, 7));
                // hold runs are sticky so latch and re-seed both get exercised
                if (held[ch])
                    held[ch] = ($urandom_range(0, 9) < 7);
                else
                    held[ch] = ($urandom_range(0, 9) < 2);
                // slow motion mostly, with jumps and raw 9-bit values
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    yaw = walk_yaw[ch] + $urandom_range(0, 40) - 20;
                    if (yaw > 180)
                        yaw -= 360;
                    if (yaw < -180)
                        yaw += 360;
                end
                else if (pick < 85)
                begin
                    yaw = $urandom_range(0, 360) - 180;
                end
                else
                begin
                    yaw = $urandom_range(0, 511);
                    if (yaw >= 256)
                        yaw -= 512;
                end
                if (yaw >= -180 && yaw <= 180)
                    walk_yaw[ch] = yaw;
                offer_item(ch, held[ch], yaw, 1'b0, 0);
                sender_gap();
            end
            drain_results();
        end

        // final settle
        repeat (8) @(posedge clk);
        $display("%0d items, %0d results over %0d register settings", item_count,
                 result_count, NUM_PHASES);
        $display("%0d items in clamp mode, %0d on unused channels", clamp_count,
                 unused_ch_count);
        if (error_count == 0 && offset_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
